/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the parity / CRC-16 block (fpc16_core).
// All macros sample on clk; ASSERT_CLK needs a signal rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/fpc16_pkg.sv */
// Package for the parity marker / CRC-16 generator: beat types, constants
// and the byte-level helper functions. No dependencies.
package fpc16_pkg;

  localparam int unsigned DEF_MAX_BLOCK_BYTES = 64;
  localparam logic [15:0] CRC_POLY            = 16'h1021;
  localparam logic [2:0]  PARITY_POS_RESET    = 3'd7;

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_PARITY_POS = 1'b0;  // word index of the only register

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  marked_byte;
    logic [15:0] crc_value;
    logic        crc_valid;
  } out_beat_t;

  // Result handed from the compute stage to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } stage_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Folding the bit-reversed byte MSB-first equals feeding the byte LSB-first.
  function automatic logic [15:0] crc_fold8(input logic [15:0] crc_in,
                                            input logic [7:0]  d);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[15] ^ d[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/fpc16_cfg.sv */
// APB register file of the parity / CRC-16 block: the parity bit position.
// Depends on fpc16_pkg.
module fpc16_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpc16_pkg::PADDR_W-1:0] paddr,
  input  logic [fpc16_pkg::PDATA_W-1:0] pwdata,
  output logic [fpc16_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [2:0]                   parity_pos
);
  import fpc16_pkg::*;

  logic hit;

  // word decode; byte offset bits are ignored
  assign hit    = (paddr[PADDR_W-1:2] == REG_PARITY_POS);
  assign pready = 1'b1;

  // register write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_pos <= PARITY_POS_RESET;
    end else if (psel && penable && pwrite && hit) begin
      parity_pos <= pwdata[2:0];
    end
  end

  // read mux
  assign prdata = hit ? {{(PDATA_W-3){1'b0}}, parity_pos} : '0;

endmodule

/* hw/rtl/fpc16_core.sv */
// Input register, running CRC state and per-byte parity / CRC logic.
// Depends on fpc16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpc16_core #(
  parameter int unsigned MAX_BLOCK_BYTES = fpc16_pkg::DEF_MAX_BLOCK_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpc16_pkg::in_beat_t in_data,
  input  logic [2:0]          parity_pos,
  input  logic                out_ready,
  output fpc16_pkg::stage_t   res
);
  import fpc16_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_BYTES);

  logic             s1_valid;
  in_beat_t         s1;
  logic [15:0]      crc_remainder;
  logic [CNT_W-1:0] bytes_seen;

  logic             advance;
  logic             under;
  logic [7:0]       marked;
  logic [15:0]      crc_upd;
  logic [CNT_W-1:0] bytes_upd;

  assign advance  = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  // parity mark and CRC fold of the held byte
  always_comb begin
    under     = (bytes_seen < CNT_MAX);
    marked    = s1.data_byte;
    crc_upd   = crc_remainder;
    bytes_upd = bytes_seen;
    if (under) begin
      if (^s1.data_byte) begin
        marked = s1.data_byte | (8'd1 << parity_pos);
      end
      crc_upd   = crc_fold8(crc_remainder, marked);
      bytes_upd = bytes_seen + 1'b1;
    end
  end

  // message state; cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_remainder <= '0;
      bytes_seen    <= '0;
    end else if (advance) begin
      if (s1.last_byte) begin
        crc_remainder <= '0;
        bytes_seen    <= '0;
      end else begin
        crc_remainder <= crc_upd;
        bytes_seen    <= bytes_upd;
      end
    end
  end

  // result beat
  always_comb begin
    res.valid            = s1_valid;
    res.beat.marked_byte = marked;
    res.beat.crc_valid   = s1.last_byte;
    res.beat.crc_value   = s1.last_byte ? {rev8(crc_upd[15:8]), rev8(crc_upd[7:0])}
                                        : 16'h0000;
  end

  `ASSERT_CLK(a_clear_after_last, advance && s1.last_byte |=> bytes_seen == '0 && crc_remainder == '0, "state not cleared after last byte")
  `ASSERT_CLK(a_count_bounded, bytes_seen <= CNT_MAX, "byte count past block limit")
  `ASSERT_CLK(a_pass_past_limit, s1_valid && !under |-> marked == s1.data_byte && crc_upd == crc_remainder, "byte past limit altered or folded")

endmodule

/* hw/rtl/fpc16_out.sv */
// Output register of the parity / CRC-16 block; holds a beat under stall.
// Depends on fpc16_pkg.
module fpc16_out (
  input  logic                 clk,
  input  logic                 rst,
  input  fpc16_pkg::stage_t    res,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fpc16_pkg::out_beat_t out_data
);
  import fpc16_pkg::*;

  // can load when empty or when the held beat leaves this cycle
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res.valid) begin
      out_data <= res.beat;
    end
  end

endmodule

/* hw/rtl/fsk_parity_crc16_generator.sv */
// Parity marker and CRC-16 (Kermit) generator for FSK message bytes.
//
// Input channel in_valid / in_stall / in_data carries one byte per beat with a
// last-byte flag. Output channel out_valid / out_stall / out_data returns one
// beat per input byte: the byte with its parity bit set when its one count is
// odd, and on the last byte the finished CRC with each byte bit-reversed.
// Bytes past MAX_BLOCK_BYTES pass unmarked and stay out of the CRC.
// Throughput: one byte per cycle while out_stall is low; the CRC fold of a
// whole byte is done in the compute stage, between the two registers.
// Path: an accepted byte passes the input register, then the output register,
// which raises out_valid; out_stall can hold a beat in either register.
// A stall on a held output beat raises in_stall in the same cycle when the
// input register holds a byte; an empty input register still takes one more.
// Reset (rst, synchronous) empties both registers, clears the running CRC
// and byte count, and sets the parity position to 7.
// The APB port writes the parity bit position at byte address 0; the user must
// write it only while no byte is in flight; the block does not enforce this.
// Depends on fpc16_pkg, fpc16_cfg, fpc16_core, fpc16_out.
module fsk_parity_crc16_generator #(
  parameter int unsigned MAX_BLOCK_BYTES = fpc16_pkg::DEF_MAX_BLOCK_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fpc16_pkg::in_beat_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fpc16_pkg::out_beat_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpc16_pkg::PADDR_W-1:0] paddr,
  input  logic [fpc16_pkg::PDATA_W-1:0] pwdata,
  output logic [fpc16_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import fpc16_pkg::*;

  logic [2:0] parity_pos;
  logic       out_ready;
  stage_t     res;

  fpc16_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .parity_pos (parity_pos)
  );

  fpc16_core #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .parity_pos (parity_pos),
    .out_ready  (out_ready),
    .res        (res)
  );

  fpc16_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for fsk_parity_crc16_generator: parity marking, Kermit CRC,
// block-limit pass-through, APB parity-position writes, random idling and back-pressure.
// Depends on fpc16_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;
  import fpc16_pkg::*;

  localparam int unsigned BLOCK_LIMIT = 64;
  localparam logic [15:0] CCITT_POLY  = 16'h1021;
  localparam int unsigned STUCK_LIMIT = 2000;   // cycles with no beat anywhere
  localparam int unsigned DRAIN_WAIT  = 8;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // DUT ports; the driven inputs are known from time zero
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_beat_t            in_data  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  fsk_parity_crc16_generator #(.MAX_BLOCK_BYTES(BLOCK_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: mirrors the block's running CRC, byte count and register
  logic [2:0]  parity_pos = PARITY_POS_RESET;
  logic [15:0] crc_rem    = '0;
  logic [6:0]  byte_count = '0;

  out_beat_t marked_beats_due[$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        stall_pct      = 0;
  int        hold_request   = 0;
  int        hold_left      = 0;
  int        stuck_cycles   = 0;

  // Mark one byte, fold it into the CRC and build the beat the block returns
  function automatic out_beat_t mark_and_fold(input in_beat_t beat);
    out_beat_t  res;
    logic [7:0] marked, flipped, crc_hi, crc_lo;
    logic       fb;
    marked = beat.data_byte;
    if (byte_count < BLOCK_LIMIT) begin
      if (^beat.data_byte) marked[parity_pos] = 1'b1;
      flipped = {<<{marked}};
      for (int i = 7; i >= 0; i--) begin
        fb      = crc_rem[15] ^ flipped[i];
        crc_rem = {crc_rem[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
      end
      byte_count++;
    end
    res.marked_byte = marked;
    res.crc_valid   = beat.last_byte;
    res.crc_value   = '0;
    if (beat.last_byte) begin
      crc_hi        = {<<{crc_rem[15:8]}};
      crc_lo        = {<<{crc_rem[7:0]}};
      res.crc_value = {crc_hi, crc_lo};
      crc_rem       = '0;
      byte_count    = '0;
    end
    return res;
  endfunction

  // Receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: each output beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (marked_beats_due.size() == 0) begin
        $error("unexpected output beat: marked_byte %h crc_value %h crc_valid %b",
               out_data.marked_byte, out_data.crc_value, out_data.crc_valid);
        mismatch_count++;
      end else begin
        want = marked_beats_due.pop_front();
        if (out_data.marked_byte !== want.marked_byte) begin
          $error("marked_byte: expected %h, actual %h", want.marked_byte,
                 out_data.marked_byte);
          mismatch_count++;
        end
        if (out_data.crc_value !== want.crc_value) begin
          $error("crc_value: expected %h, actual %h", want.crc_value, out_data.crc_value);
          mismatch_count++;
        end
        if (out_data.crc_valid !== want.crc_valid) begin
          $error("crc_valid: expected %b, actual %b", want.crc_valid, out_data.crc_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it; returns after acceptance
  task automatic send_byte(input logic [7:0] data, input logic last);
    in_beat_t beat;
    beat.data_byte = data;
    beat.last_byte = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    marked_beats_due.push_back(mark_and_fold(beat));
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (marked_beats_due.size() != 0) @(posedge clk);
  endtask

  // APB write of the parity position; only called with nothing in flight
  task automatic write_parity_pos(input logic [2:0] pos);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PARITY_POS, 2'b00};
    pwdata  <= PDATA_W'(pos);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    parity_pos = pos;
  endtask

  // Field extremes, odd/even bytes, parity bit already set, one-byte messages
  task automatic test_directed_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    drain_results();
  endtask

  // Lowest, highest and one middle parity position
  task automatic test_parity_positions();
    logic [2:0] positions[3];
    positions = '{3'd0, 3'd7, 3'($urandom_range(1, 6))};
    foreach (positions[k]) begin
      write_parity_pos(positions[k]);
      send_byte(8'h02, 1'b0);                                 // odd; bit clear unless position is 1
      send_byte(8'h01 << positions[k], 1'b0);                 // odd, bit already set
      send_byte(8'h03, 1'b1);                                 // even
      drain_results();
    end
  endtask

  // Messages at, just over and well over the block limit
  task automatic test_block_limit();
    send_message(BLOCK_LIMIT);
    send_message(BLOCK_LIMIT + 1);
    send_message(BLOCK_LIMIT + 30);
    drain_results();
  endtask

  // Receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 300;
    send_message(40);
    drain_results();
  endtask

  // Random messages under each idling mix, new parity position per phase
  task automatic test_random_messages();
    int idle_mix[4]  = '{0, 50, 0, 28};
    int stall_mix[4] = '{0, 0, 50, 28};
    int sent;
    int len;
    for (int p = 0; p < 4; p++) begin
      write_parity_pos(3'($urandom_range(0, 7)));
      send_idle_pct = idle_mix[p];
      stall_pct     = stall_mix[p];
      sent = 0;
      while (sent < 50) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(60, 100);
        else len = $urandom_range(1, 12);
        send_message(len);
        sent += len;
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_bytes();
    test_parity_positions();
    test_block_limit();
    test_backpressure();
    test_random_messages();
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (marked_beats_due.size() != 0) begin
      $error("%0d output beats never arrived", marked_beats_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fpc16_pkg.sv
hw/rtl/fpc16_cfg.sv
hw/rtl/fpc16_core.sv
hw/rtl/fpc16_out.sv
hw/rtl/fsk_parity_crc16_generator.sv
test/tb_top.sv
